FILE: rtl/zvdc_pkg.sv
// zoom viewport dead-zone camera: shared constants, types and helpers
// no dependencies; used by the interfaces, the divider and the top level
package zvdc_pkg;

  localparam int MAX_DIMENSION = 8192;
  localparam int SUBPIXEL_BITS = 4;

  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int ZOOM_W    = 16;
  localparam int CUR_W     = 19;
  localparam int BOX_W     = 18;
  localparam int SW        = 21;
  localparam int Q8_BITS   = 8;
  localparam int DVD_W     = BOX_W + Q8_BITS;
  localparam int REM_W     = ZOOM_W + 1;
  localparam int DIV_STEPS = BOX_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [ZOOM_W-1:0] ONE_Q8 = ZOOM_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_MONITOR_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MONITOR_HEIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DETACHED_ENABLE = CFG_IDX_W'(2);

  localparam logic [CFG_W-1:0] RST_MONITOR_WIDTH  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] RST_MONITOR_HEIGHT = CFG_W'(1080);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_W,
    ST_DIV_H,
    ST_POS,
    ST_ZCLAMP,
    ST_PUSH,
    ST_CLAMP,
    ST_OUT
  } state_t;

  // monitor size in subpixel units, pixel count held to 1..MAX_DIMENSION
  function automatic logic [BOX_W-1:0] dim_sub(input logic [CFG_W-1:0] p);
    logic [BOX_W-1:0] r;
    if (p == '0) begin
      r = BOX_W'(1) << SUBPIXEL_BITS;
    end else if (BOX_W'(p) > BOX_W'(MAX_DIMENSION)) begin
      r = BOX_W'(MAX_DIMENSION) << SUBPIXEL_BITS;
    end else begin
      r = BOX_W'(p) << SUBPIXEL_BITS;
    end
    return r;
  endfunction

  // upper bound first, then zero floor
  function automatic logic signed [SW-1:0] clamp_pos(input logic signed [SW-1:0] v,
                                                     input logic signed [SW-1:0] hi);
    logic signed [SW-1:0] r;
    r = (v > hi) ? hi : v;
    if (r < 0) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/zvdc_if.sv
// request channel interfaces for the zoom viewport camera
// depends on zvdc_pkg
interface zvdc_frame_if import zvdc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ZOOM_W-1:0]        zoom_level;
  logic signed [CUR_W-1:0]  cursor_x;
  logic signed [CUR_W-1:0]  cursor_y;
  logic                     follow_cursor;
  logic                     force_detached;
  logic                     anim_done;

  modport source (output valid, zoom_level, cursor_x, cursor_y, follow_cursor,
                  force_detached, anim_done, input ready);
  modport sink (input valid, zoom_level, cursor_x, cursor_y, follow_cursor,
                force_detached, anim_done, output ready);
endinterface

interface zvdc_box_if import zvdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             box_valid;
  logic [BOX_W-1:0] source_x;
  logic [BOX_W-1:0] source_y;
  logic [BOX_W-1:0] source_w;
  logic [BOX_W-1:0] source_h;

  modport source (output valid, box_valid, source_x, source_y, source_w, source_h,
                  input ready);
  modport sink (input valid, box_valid, source_x, source_y, source_w, source_h,
                output ready);
endinterface

FILE: rtl/zvdc_div.sv
// shared radix-4 restoring divider: monitor size * 256 over zoom
// depends on zvdc_pkg; two quotient bits per cycle
module zvdc_div import zvdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [ZOOM_W-1:0] divisor,
  output logic              done,
  output logic [BOX_W-1:0]  quotient
);

  logic [REM_W-1:0]  rem;
  logic [BOX_W-1:0]  dvd_lo;
  logic [ZOOM_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [REM_W:0]   t1, t2;
  logic             ge1, ge2;
  logic [REM_W-1:0] r1, r2;

  always_comb begin
    t1  = {rem, dvd_lo[BOX_W-1]};
    ge1 = t1 >= (REM_W+1)'(dsr);
    r1  = ge1 ? REM_W'(t1 - (REM_W+1)'(dsr)) : REM_W'(t1);
    t2  = {r1, dvd_lo[BOX_W-2]};
    ge2 = t2 >= (REM_W+1)'(dsr);
    r2  = ge2 ? REM_W'(t2 - (REM_W+1)'(dsr)) : REM_W'(t2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // top quotient bits are known zero, so the upper dividend seeds the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= REM_W'(dividend[DVD_W-1:BOX_W]);
      dvd_lo   <= dividend[BOX_W-1:0];
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= r2;
      dvd_lo   <= {dvd_lo[BOX_W-3:0], 2'b00};
      quotient <= {quotient[BOX_W-3:0], ge1, ge2};
    end
  end

endmodule

FILE: rtl/zoom_viewport_deadzone_camera.sv
// zoom viewport with dead-zone camera, top level: config, sequencer, datapath
// depends on zvdc_pkg, zvdc_if and zvdc_div
//
//   channel  | dir | handshake          | payload
//   frame    | in  | valid / ready      | zoom_level, cursor_x/y, follow_cursor,
//            |     |                    | force_detached, anim_done
//   box      | out | valid / ready      | box_valid, source_x/y/w/h
//   cfg      | in  | cfg_we (no stall)  | cfg_index, cfg_data
//
// one request at a time; zoom at or below 1.0 gives its result in the cycle after accept
// otherwise the result follows two passes through the shared divider (width, then height)
// and two to four position steps
// frame.ready is high only in idle; a held result stalls the block until taken
// rst (synchronous) restores config defaults and arms a re-anchor
module zoom_viewport_deadzone_camera import zvdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  zvdc_frame_if.sink           frame,
  zvdc_box_if.source           box
);

  state_t state, state_next;

  logic [CFG_W-1:0] monitor_width;
  logic [CFG_W-1:0] monitor_height;
  logic             detached_enable;

  logic [ZOOM_W-1:0]       zoom;
  logic signed [CUR_W-1:0] cx, cy;
  logic                    follow, force_det, anim;

  logic [BOX_W-1:0]     w, h;
  logic signed [SW-1:0] x, y;

  logic [BOX_W-1:0]  camera_x, camera_y, camera_w, camera_h;
  logic [ZOOM_W-1:0] previous_zoom;
  logic              reanchor_pending;

  logic             res_valid;
  logic [BOX_W-1:0] res_x, res_y, res_w, res_h;

  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dividend;
  logic [ZOOM_W-1:0] div_divisor;
  logic [BOX_W-1:0]  div_q;

  logic [BOX_W-1:0]     mw, mh;
  logic signed [SW-1:0] smw, smh, sw_w, sw_h, scx, scy, ax, ay;
  logic signed [SW-1:0] cx_push, cy_push, cx_clamp, cy_clamp;
  logic [BOX_W-1:0]     w_min, h_min;
  logic                 accept, low_zoom, detached;

  assign mw       = dim_sub(monitor_width);
  assign mh       = dim_sub(monitor_height);
  assign smw      = SW'(mw);
  assign smh      = SW'(mh);
  assign sw_w     = SW'(w);
  assign sw_h     = SW'(h);
  assign scx      = SW'(cx);
  assign scy      = SW'(cy);
  assign ax       = follow ? scx : (smw >>> 1);
  assign ay       = follow ? scy : (smh >>> 1);
  assign accept   = frame.valid && frame.ready;
  assign low_zoom = frame.zoom_level <= ONE_Q8;
  assign detached = (detached_enable || force_det) && follow && anim;

  // dead-zone push
  assign cx_push = (scx < x) ? scx : ((scx > x + sw_w) ? scx - sw_w : x);
  assign cy_push = (scy < y) ? scy : ((scy > y + sw_h) ? scy - sw_h : y);
  assign w_min   = (w > mw) ? mw : w;
  assign h_min   = (h > mh) ? mh : h;
  assign cx_clamp = clamp_pos(x, smw - sw_w);
  assign cy_clamp = clamp_pos(y, smh - sw_h);

  assign div_dividend = (state == ST_IDLE) ? {mw, Q8_BITS'(0)} : {mh, Q8_BITS'(0)};
  assign div_divisor  = (state == ST_IDLE) ? frame.zoom_level : zoom;

  zvdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_width   <= RST_MONITOR_WIDTH;
      monitor_height  <= RST_MONITOR_HEIGHT;
      detached_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MONITOR_WIDTH:   monitor_width   <= cfg_data;
        REG_MONITOR_HEIGHT:  monitor_height  <= cfg_data;
        REG_DETACHED_ENABLE: detached_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = low_zoom ? ST_OUT : ST_DIV_W;
        end
      end
      ST_DIV_W: begin
        if (div_done) begin
          state_next = ST_DIV_H;
        end
      end
      ST_DIV_H: begin
        if (div_done) begin
          state_next = ST_POS;
        end
      end
      ST_POS: begin
        priority if (!detached || reanchor_pending) begin
          state_next = ST_CLAMP;
        end else if (previous_zoom != zoom) begin
          state_next = ST_ZCLAMP;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_ZCLAMP: state_next = ST_PUSH;
      ST_PUSH:   state_next = ST_CLAMP;
      ST_CLAMP:  state_next = ST_OUT;
      ST_OUT: begin
        if (box.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    frame.ready = (state == ST_IDLE);
    box.valid   = (state == ST_OUT);
    div_start   = ((state == ST_IDLE) && accept && !low_zoom) ||
                  ((state == ST_DIV_W) && div_done);
  end

  assign box.box_valid = res_valid;
  assign box.source_x  = res_x;
  assign box.source_y  = res_y;
  assign box.source_w  = res_w;
  assign box.source_h  = res_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // camera state
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x         <= '0;
      camera_y         <= '0;
      camera_w         <= '0;
      camera_h         <= '0;
      previous_zoom    <= '0;
      reanchor_pending <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && low_zoom) begin
            reanchor_pending <= 1'b1;
          end
        end
        ST_POS: begin
          if (!detached) begin
            reanchor_pending <= 1'b1;
          end else if (reanchor_pending) begin
            reanchor_pending <= 1'b0;
            previous_zoom    <= zoom;
          end
        end
        ST_ZCLAMP: previous_zoom <= zoom;
        ST_CLAMP: begin
          if (detached) begin
            camera_x <= cx_clamp[BOX_W-1:0];
            camera_y <= cy_clamp[BOX_W-1:0];
            camera_w <= w;
            camera_h <= h;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          zoom      <= frame.zoom_level;
          cx        <= frame.cursor_x;
          cy        <= frame.cursor_y;
          follow    <= frame.follow_cursor;
          force_det <= frame.force_detached;
          anim      <= frame.anim_done;
          res_valid <= 1'b0;
          res_x     <= '0;
          res_y     <= '0;
          res_w     <= '0;
          res_h     <= '0;
        end
      end
      ST_DIV_W: begin
        if (div_done) begin
          w <= div_q;
        end
      end
      ST_DIV_H: begin
        if (div_done) begin
          h <= div_q;
        end
      end
      ST_POS: begin
        priority if (!detached) begin
          x <= ax - (sw_w >>> 1);
          y <= ay - (sw_h >>> 1);
        end else if (reanchor_pending) begin
          x <= scx - (sw_w >>> 1);
          y <= scy - (sw_h >>> 1);
        end else if (previous_zoom != zoom) begin
          // resize about the old centre
          x <= SW'(camera_x) + (SW'(camera_w) >>> 1) - (sw_w >>> 1);
          y <= SW'(camera_y) + (SW'(camera_h) >>> 1) - (sw_h >>> 1);
        end else begin
          x <= SW'(camera_x);
          y <= SW'(camera_y);
          w <= camera_w;
          h <= camera_h;
        end
      end
      ST_ZCLAMP: begin
        x <= cx_clamp;
        y <= cy_clamp;
      end
      ST_PUSH: begin
        x <= cx_push;
        y <= cy_push;
        w <= w_min;
        h <= h_min;
      end
      ST_CLAMP: begin
        res_valid <= 1'b1;
        res_x     <= cx_clamp[BOX_W-1:0];
        res_y     <= cy_clamp[BOX_W-1:0];
        res_w     <= w;
        res_h     <= h;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

endmodule
